FILE: hw/rtl/addressable_led_serializer_defines.svh
// Assertion macros for the addressable LED serializer.
// Used by the top level only; the bodies are empty when SYNTHESIS is defined.
`ifndef ADDRESSABLE_LED_SERIALIZER_DEFINES_SVH
`define ADDRESSABLE_LED_SERIALIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define ALS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("addressable_led_serializer: check failed");
`define ALS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("addressable_led_serializer: check failed");
`else
`define ALS_ASSERT_IMP(label, ante, cons)
`define ALS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hw/rtl/als_pkg.sv
// Shared types and constants of the addressable LED serializer.
// No dependencies; imported by every module of the block.
package als_pkg;

  localparam int MAX_LEDS_DEFAULT = 64;
  localparam int PIXEL_W          = 32;

  localparam logic [15:0] HIGH_ONE_RESET    = 16'd58;
  localparam logic [15:0] HIGH_ZERO_RESET   = 16'd29;
  localparam logic [15:0] PERIOD_RESET      = 16'd89;
  localparam logic [9:0]  RESET_SLOTS_RESET = 10'd50;
  localparam logic [6:0]  ACTIVE_RESET      = 7'd64;
  localparam logic        WHITE_RESET       = 1'b0;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FILL  = 2'd1,
    OP_START = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_HIGH_ONE    = 3'd0,
    REG_HIGH_ZERO   = 3'd1,
    REG_PERIOD      = 3'd2,
    REG_RESET_SLOTS = 3'd3,
    REG_ACTIVE      = 3'd4,
    REG_WHITE       = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_DATA  = 3'b010,
    PH_RESET = 3'b100
  } phase_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } out_item_t;

  typedef struct packed {
    logic [15:0] high_ticks_one;
    logic [15:0] high_ticks_zero;
    logic [15:0] period_ticks;
    logic [9:0]  reset_slot_count;
    logic [6:0]  active_leds;
    logic        white_enable;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic tick;
  } frame_cmd_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  channel;
    logic [2:0]  bit_pos;
    logic [15:0] slot_tick;
    logic        done;
  } frame_state_t;

endpackage

FILE: hw/rtl/als_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on als_pkg for its default sizes.
module als_ram import als_pkg::*; #(
  parameter int WIDTH = PIXEL_W,
  parameter int DEPTH = MAX_LEDS_DEFAULT,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/als_frame.sv
// Frame sequencer: slot timer, bit, channel and pixel counters and the reset slots.
// Depends on als_pkg; driven by the top level once per accepted request.
module als_frame import als_pkg::*; #(
  parameter int MAX_LEDS = MAX_LEDS_DEFAULT,
  localparam int AW      = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1,
  localparam int CW      = $clog2(MAX_LEDS + 1),
  localparam int KW      = (CW > 8) ? CW : 8
) (
  input  logic          clk,
  input  logic          rst,
  input  frame_cmd_t    cmd,
  input  cfg_t          cfg,
  input  logic [KW-1:0] led_cnt,
  output frame_state_t  fs,
  output logic [AW-1:0] pixel_pos_next
);

  phase_t      phase, phase_next;
  logic [AW-1:0] pixel_pos;
  logic [1:0]  channel, channel_next;
  logic [2:0]  bit_pos, bit_pos_next;
  logic [15:0] slot_tick, slot_tick_next;
  logic [9:0]  sent, sent_next;
  logic        done, done_next;
  logic [2:0]  channels;

  assign channels = cfg.white_enable ? 3'd4 : 3'd3;

  always_comb begin
    phase_next     = phase;
    pixel_pos_next = pixel_pos;
    channel_next   = channel;
    bit_pos_next   = bit_pos;
    slot_tick_next = slot_tick;
    sent_next      = sent;
    done_next      = 1'b0;
    if (cmd.start && phase == PH_IDLE) begin
      pixel_pos_next = '0;
      channel_next   = '0;
      bit_pos_next   = '0;
      slot_tick_next = '0;
      sent_next      = '0;
      if (led_cnt != '0) begin
        phase_next = PH_DATA;
      end else if (cfg.reset_slot_count == '0) begin
        phase_next = PH_IDLE;
        done_next  = 1'b1;
      end else begin
        phase_next = PH_RESET;
      end
    end else if (cmd.tick && phase != PH_IDLE) begin
      if (slot_tick < cfg.period_ticks) begin
        slot_tick_next = slot_tick + 16'd1;
      end else begin
        slot_tick_next = '0;
        if (phase == PH_DATA) begin
          if (bit_pos != 3'd7) begin
            bit_pos_next = bit_pos + 3'd1;
          end else begin
            bit_pos_next = '0;
            if ({1'b0, channel} + 3'd1 < channels) begin
              channel_next = channel + 2'd1;
            end else begin
              channel_next = '0;
              if (KW'(pixel_pos) + KW'(1) < led_cnt) begin
                pixel_pos_next = pixel_pos + AW'(1);
              end else begin
                pixel_pos_next = '0;
                sent_next      = '0;
                if (cfg.reset_slot_count == '0) begin
                  phase_next = PH_IDLE;
                  done_next  = 1'b1;
                end else begin
                  phase_next = PH_RESET;
                end
              end
            end
          end
        end else if ({1'b0, sent} + 11'd1 >= {1'b0, cfg.reset_slot_count}) begin
          sent_next  = '0;
          phase_next = PH_IDLE;
          done_next  = 1'b1;
        end else begin
          sent_next = sent + 10'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      pixel_pos <= '0;
      channel   <= '0;
      bit_pos   <= '0;
      slot_tick <= '0;
      sent      <= '0;
      done      <= 1'b0;
    end else if (cmd.accept) begin
      phase     <= phase_next;
      pixel_pos <= pixel_pos_next;
      channel   <= channel_next;
      bit_pos   <= bit_pos_next;
      slot_tick <= slot_tick_next;
      sent      <= sent_next;
      done      <= done_next;
    end
  end

  assign fs = '{phase: phase, channel: channel, bit_pos: bit_pos,
                slot_tick: slot_tick, done: done};

endmodule

FILE: hw/rtl/addressable_led_serializer.sv
// Channel  Handshake           Payload
// in       in_valid/in_stall   in_req  (in_item_t: operation, index, colors)
// out      out_valid/out_stall out_res (out_item_t: line level, busy, frame done)
// cfg      cfg_we              cfg_index, cfg_data
// A write, start or tick request: accept, then the pixel read, whose result is registered once the output is free.
// A fill request sweeps the pixel RAM one entry a cycle, then reads out like the others.
// After reset a clearing pass zeroes every RAM entry with in_stall high.
// The result sits in an output register, so a new request is taken while it waits.
// Depends on als_pkg, als_ram, als_frame and the assertion macro header.
`include "addressable_led_serializer_defines.svh"
module addressable_led_serializer import als_pkg::*; #(
  parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_req,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = $clog2(MAX_LEDS + 1);
  localparam int KW = (CW > 8) ? CW : 8;

  typedef enum logic [3:0] {
    SQ_CLEAR = 4'b0001,
    SQ_IDLE  = 4'b0010,
    SQ_FILL  = 4'b0100,
    SQ_LOOK  = 4'b1000
  } sq_t;

  sq_t            sq, sq_next;
  cfg_t           cfg;
  logic [KW-1:0]  led_cnt;
  logic           acc, wr_hit, out_free, sweep_last;
  logic [AW-1:0]  sweep, rd_pos;
  logic [31:0]    word, fill_word, fwd_word, cur_word, rdata;
  logic           fwd;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [31:0]    ram_wdata;
  logic [7:0]     cur_byte;
  logic           cur_bit, level;
  logic [15:0]    high_time;
  frame_cmd_t     cmd;
  frame_state_t   fs;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{high_ticks_one: HIGH_ONE_RESET, high_ticks_zero: HIGH_ZERO_RESET,
               period_ticks: PERIOD_RESET, reset_slot_count: RESET_SLOTS_RESET,
               active_leds: ACTIVE_RESET, white_enable: WHITE_RESET};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_ONE:    cfg.high_ticks_one   <= cfg_data;
        REG_HIGH_ZERO:   cfg.high_ticks_zero  <= cfg_data;
        REG_PERIOD:      cfg.period_ticks     <= cfg_data;
        REG_RESET_SLOTS: cfg.reset_slot_count <= cfg_data[9:0];
        REG_ACTIVE:      cfg.active_leds      <= cfg_data[6:0];
        REG_WHITE:       cfg.white_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign led_cnt = (KW'(cfg.active_leds) > KW'(MAX_LEDS)) ? KW'(MAX_LEDS)
                                                          : KW'(cfg.active_leds);

  assign in_stall   = (sq != SQ_IDLE);
  assign acc        = in_valid && !in_stall;
  assign word       = {in_req.green, in_req.red, in_req.blue, in_req.white};
  assign wr_hit     = acc && in_req.operation == OP_WRITE
                      && KW'(in_req.pixel_index) < led_cnt;
  assign sweep_last = (sweep == AW'(MAX_LEDS - 1));
  assign out_free   = !out_valid || !out_stall;

  assign cmd = '{accept: acc,
                 start: acc && in_req.operation == OP_START,
                 tick: acc && in_req.operation == OP_TICK};

  als_frame #(.MAX_LEDS(MAX_LEDS)) u_frame (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .led_cnt        (led_cnt),
    .fs             (fs),
    .pixel_pos_next (rd_pos)
  );

  always_comb begin
    ram_we    = wr_hit;
    ram_waddr = AW'(in_req.pixel_index);
    ram_wdata = word;
    if (sq == SQ_CLEAR || sq == SQ_FILL) begin
      ram_we    = 1'b1;
      ram_waddr = sweep;
      ram_wdata = (sq == SQ_FILL) ? fill_word : '0;
    end
  end

  als_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_LEDS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (acc),
    .raddr (rd_pos),
    .rdata (rdata)
  );

  always_comb begin
    sq_next = sq;
    case (sq)
      SQ_CLEAR: if (sweep_last) sq_next = SQ_IDLE;
      SQ_IDLE: begin
        if (acc) begin
          sq_next = (in_req.operation == OP_FILL) ? SQ_FILL : SQ_LOOK;
        end
      end
      SQ_FILL:  if (sweep_last) sq_next = SQ_LOOK;
      SQ_LOOK:  if (out_free) sq_next = SQ_IDLE;
      default:  sq_next = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq    <= SQ_CLEAR;
      sweep <= '0;
    end else begin
      sq <= sq_next;
      if (sq == SQ_CLEAR || sq == SQ_FILL) begin
        sweep <= sweep_last ? '0 : sweep + AW'(1);
      end
    end
  end

  // A fill leaves every entry equal to the fill word, so the read is bypassed.
  always_ff @(posedge clk) begin
    if (acc) begin
      fwd       <= wr_hit && AW'(in_req.pixel_index) == rd_pos;
      fwd_word  <= word;
      fill_word <= word;
    end else if (sq == SQ_FILL && sweep_last) begin
      fwd      <= 1'b1;
      fwd_word <= fill_word;
    end
  end

  assign cur_word = fwd ? fwd_word : rdata;

  always_comb begin
    case (fs.channel)
      2'd0:    cur_byte = cur_word[31:24];
      2'd1:    cur_byte = cur_word[23:16];
      2'd2:    cur_byte = cur_word[15:8];
      default: cur_byte = cur_word[7:0];
    endcase
  end

  assign cur_bit   = cur_byte[3'd7 - fs.bit_pos];
  assign high_time = cur_bit ? cfg.high_ticks_one : cfg.high_ticks_zero;
  assign level     = (fs.phase == PH_DATA) && (fs.slot_tick < high_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sq == SQ_LOOK && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sq == SQ_LOOK && out_free) begin
      out_res <= '{line_level: level, busy_res: fs.phase != PH_IDLE,
                   frame_done: fs.done};
    end
  end

  `ALS_ASSERT_IMP(a_idle_line_low, out_valid && !out_res.busy_res, !out_res.line_level)
  `ALS_ASSERT_IMP(a_done_not_busy, out_valid && out_res.frame_done, !out_res.busy_res)
  `ALS_ASSERT_NEXT(a_accept_to_look, acc, sq == SQ_LOOK || sq == SQ_FILL)
  `ALS_ASSERT_NEXT(a_fill_holds_frame, sq == SQ_FILL, $stable(fs.slot_tick) && $stable(rd_pos))

endmodule

FILE: bench/led_frame_checker.sv
// Watches the request, result and register ports of the LED serializer, predicts each result
// and compares it with what the block returns.
// Depends on als_pkg for the request, result and register types.
`timescale 1ns / 100ps
module led_frame_checker import als_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_req,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          awaiting
);

  localparam int LED_SLOTS = MAX_LEDS_DEFAULT;
  localparam int LED_AW    = $clog2(LED_SLOTS);

  cfg_t        regs;
  logic [31:0] pixels [LED_SLOTS];
  phase_t      seq_phase;
  logic [6:0]  pix_pos;
  logic [1:0]  chan_pos;
  logic [2:0]  bit_pos;
  logic [15:0] slot_cnt;
  logic [9:0]  resets_sent;
  out_item_t   line_states_q [$];

  task automatic note_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int led_limit();
    return (int'(regs.active_leds) > LED_SLOTS) ? LED_SLOTS : int'(regs.active_leds);
  endfunction

  function automatic logic line_now();
    logic [31:0] word;
    logic [7:0]  lane_byte;
    logic [15:0] high_len;
    if (seq_phase != PH_DATA || int'(pix_pos) >= LED_SLOTS) return 1'b0;
    word = pixels[pix_pos[LED_AW-1:0]];
    lane_byte = word[8 * (3 - int'(chan_pos)) +: 8];
    high_len = lane_byte[3'd7 - bit_pos] ? regs.high_ticks_one : regs.high_ticks_zero;
    return slot_cnt < high_len;
  endfunction

  function automatic logic begin_reset_slots();
    resets_sent = '0;
    if (regs.reset_slot_count == '0) begin
      seq_phase = PH_IDLE;
      return 1'b1;
    end
    seq_phase = PH_RESET;
    return 1'b0;
  endfunction

  function automatic logic advance_timer();
    int lanes;
    lanes = regs.white_enable ? 4 : 3;
    if (seq_phase == PH_IDLE) return 1'b0;
    if (slot_cnt < regs.period_ticks) begin
      slot_cnt++;
      return 1'b0;
    end
    slot_cnt = '0;
    if (seq_phase == PH_DATA) begin
      if (bit_pos < 3'd7) begin
        bit_pos++;
        return 1'b0;
      end
      bit_pos = '0;
      if (int'(chan_pos) + 1 < lanes) begin
        chan_pos++;
        return 1'b0;
      end
      chan_pos = '0;
      if (int'(pix_pos) + 1 < led_limit()) begin
        pix_pos++;
        return 1'b0;
      end
      pix_pos = '0;
      return begin_reset_slots();
    end
    resets_sent++;
    if (resets_sent >= regs.reset_slot_count) begin
      resets_sent = '0;
      seq_phase = PH_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic step_serializer(input in_item_t r, output out_item_t res);
    logic [31:0] word;
    logic        done;
    word = {r.green, r.red, r.blue, r.white};
    done = 1'b0;
    case (r.operation)
      OP_WRITE: begin
        if (int'(r.pixel_index) < led_limit()) pixels[r.pixel_index[LED_AW-1:0]] = word;
      end
      OP_FILL: begin
        foreach (pixels[k]) pixels[k] = word;
      end
      OP_START: begin
        if (seq_phase == PH_IDLE) begin
          pix_pos = '0;
          chan_pos = '0;
          bit_pos = '0;
          slot_cnt = '0;
          resets_sent = '0;
          if (led_limit() > 0) seq_phase = PH_DATA;
          else done = begin_reset_slots();
        end
      end
      default: begin
        done = advance_timer();
      end
    endcase
    res.line_level = line_now();
    res.busy_res = (seq_phase != PH_IDLE);
    res.frame_done = done;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      regs.high_ticks_one = HIGH_ONE_RESET;
      regs.high_ticks_zero = HIGH_ZERO_RESET;
      regs.period_ticks = PERIOD_RESET;
      regs.reset_slot_count = RESET_SLOTS_RESET;
      regs.active_leds = ACTIVE_RESET;
      regs.white_enable = WHITE_RESET;
      foreach (pixels[k]) pixels[k] = '0;
      seq_phase = PH_IDLE;
      pix_pos = '0;
      chan_pos = '0;
      bit_pos = '0;
      slot_cnt = '0;
      resets_sent = '0;
      line_states_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HIGH_ONE:    regs.high_ticks_one = cfg_data;
          REG_HIGH_ZERO:   regs.high_ticks_zero = cfg_data;
          REG_PERIOD:      regs.period_ticks = cfg_data;
          REG_RESET_SLOTS: regs.reset_slot_count = cfg_data[9:0];
          REG_ACTIVE:      regs.active_leds = cfg_data[6:0];
          REG_WHITE:       regs.white_enable = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        step_serializer(in_req, want);
        line_states_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (line_states_q.size() == 0) begin
          note_mismatch("result with no request outstanding");
        end else begin
          want = line_states_q.pop_front();
          if (out_res.line_level !== want.line_level)
            note_mismatch($sformatf("line_level %b, expected %b",
                                    out_res.line_level, want.line_level));
          if (out_res.busy_res !== want.busy_res)
            note_mismatch($sformatf("busy_res %b, expected %b",
                                    out_res.busy_res, want.busy_res));
          if (out_res.frame_done !== want.frame_done)
            note_mismatch($sformatf("frame_done %b, expected %b",
                                    out_res.frame_done, want.frame_done));
        end
      end
    end
    awaiting <= line_states_q.size();
  end

endmodule

FILE: bench/addressable_led_serializer_tb.sv
// Top of the LED serializer bench: clock, reset, register settings, request stimulus and output stalls.
// Depends on als_pkg, the serializer RTL and led_frame_checker, which does all the checking.
`timescale 1ns / 100ps
module addressable_led_serializer_tb;
  import als_pkg::*;

  localparam logic [2:0] REG_NONE = 3'd7;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_res;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          mismatches;
  int          awaiting;

  int sent = 0;
  int burst_left = 1;
  int led_cap = MAX_LEDS_DEFAULT;
  int stall_mode = 0;
  int stall_left = 0;

  addressable_led_serializer dut (
    .clk, .rst, .in_valid, .in_stall, .in_req, .out_valid, .out_stall, .out_res,
    .cfg_we, .cfg_index, .cfg_data
  );

  led_frame_checker frame_check (
    .clk, .rst, .in_valid, .in_stall, .in_req, .out_valid, .out_stall, .out_res,
    .cfg_we, .cfg_index, .cfg_data, .mismatches, .awaiting
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= (stall_left % 4 == 0);
    endcase
  end

  function automatic in_item_t pack_req(input op_t op, input logic [7:0] idx,
                                        input logic [7:0] g, r, b, w);
    in_item_t q;
    q.operation = op;
    q.pixel_index = idx;
    q.green = g;
    q.red = r;
    q.blue = b;
    q.white = w;
    return q;
  endfunction

  function automatic cfg_t setting(input logic [15:0] one, zero, period,
                                   input logic [9:0] slots, input logic [6:0] leds,
                                   input logic white);
    cfg_t c;
    c.high_ticks_one = one;
    c.high_ticks_zero = zero;
    c.period_ticks = period;
    c.reset_slot_count = slots;
    c.active_leds = leds;
    c.white_enable = white;
    return c;
  endfunction

  function automatic cfg_t random_setting();
    return setting(16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
                   16'($urandom_range(0, 3)), 10'($urandom_range(0, 3)),
                   7'($urandom_range(1, 4)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic in_item_t random_req();
    in_item_t   q;
    logic [63:0] bits;
    int         roll;
    bits = {$urandom, $urandom};
    q = bits[$bits(in_item_t)-1:0];
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      q.operation = OP_TICK;
    end else if (roll < 85) begin
      q.operation = OP_WRITE;
      if (led_cap > 0 && $urandom_range(0, 3) != 0)
        q.pixel_index = 8'($urandom_range(0, led_cap - 1));
    end else if (roll < 96) begin
      q.operation = OP_START;
    end else begin
      q.operation = OP_FILL;
    end
    return q;
  endfunction

  task automatic issue(input in_item_t r);
    in_req <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic apply_setting(input cfg_t c);
    put_reg(REG_HIGH_ONE, c.high_ticks_one);
    put_reg(REG_HIGH_ZERO, c.high_ticks_zero);
    put_reg(REG_PERIOD, c.period_ticks);
    put_reg(REG_RESET_SLOTS, {6'($urandom), c.reset_slot_count});
    put_reg(REG_ACTIVE, {9'($urandom), c.active_leds});
    put_reg(REG_WHITE, {15'($urandom), c.white_enable});
    cfg_we <= 1'b0;
    led_cap = (int'(c.active_leds) > MAX_LEDS_DEFAULT) ? MAX_LEDS_DEFAULT : int'(c.active_leds);
  endtask

  initial begin
    in_item_t tick_req;
    int       round;
    tick_req = pack_req(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    issue(pack_req(OP_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    issue(pack_req(OP_WRITE, 8'd63, 8'h01, 8'h80, 8'h7F, 8'hFE));
    issue(pack_req(OP_WRITE, 8'd64, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    issue(pack_req(OP_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    issue(pack_req(OP_FILL, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    issue(pack_req(OP_FILL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(pack_req(OP_WRITE, 8'd0, 8'hA5, 8'h5A, 8'hC3, 8'h3C));
    issue(pack_req(OP_START, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    repeat (3) issue(tick_req);
    issue(pack_req(OP_START, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(pack_req(OP_WRITE, 8'd0, 8'h0F, 8'hF0, 8'h33, 8'hCC));
    issue(pack_req(OP_FILL, 8'd0, 8'h81, 8'h42, 8'h24, 8'h18));
    issue(tick_req);
    settle();

    put_reg(REG_NONE, 16'($urandom));
    apply_setting(setting(16'd1, 16'd0, 16'd0, 10'd0, 7'd0, 1'b1));
    repeat (40) issue(tick_req);
    issue(pack_req(OP_START, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    issue(tick_req);
    settle();

    apply_setting(setting(16'hFFFF, 16'd3, 16'd2, 10'd1, 7'd100, 1'b0));
    issue(pack_req(OP_WRITE, 8'd99, 8'h12, 8'h34, 8'h56, 8'h78));
    issue(pack_req(OP_WRITE, 8'd63, 8'h00, 8'hFF, 8'h00, 8'hFF));
    issue(pack_req(OP_START, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    repeat (10) issue(tick_req);
    settle();

    apply_setting(setting(16'd0, 16'd0, 16'hFFFF, 10'd1023, 7'd64, 1'b1));
    repeat (5) issue(tick_req);

    round = 0;
    while (sent < 850) begin
      settle();
      if (round % 4 == 3) begin
        case ($urandom_range(0, 3))
          0: apply_setting(setting(16'd0, 16'hFFFF, 16'd0, 10'd1023, 7'd2, 1'b1));
          1: apply_setting(setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd0, 7'd127, 1'b0));
          2: apply_setting(setting(16'd0, 16'd0, 16'd1, 10'd0, 7'd1, 1'b0));
          default: apply_setting(setting(16'd1, 16'd0, 16'd0, 10'd1, 7'd64, 1'b1));
        endcase
      end else begin
        apply_setting(random_setting());
      end
      repeat ($urandom_range(30, 100)) issue(random_req());
      round++;
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("addressable_led_serializer_tb OK");
    else $display("addressable_led_serializer_tb NOT OK");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("addressable_led_serializer_tb NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/als_pkg.sv
hw/rtl/als_ram.sv
hw/rtl/als_frame.sv
hw/rtl/addressable_led_serializer.sv
bench/led_frame_checker.sv
bench/addressable_led_serializer_tb.sv
